// File: hdl/ffba_pkg.sv
// Shared types, codes and default sizes for the first-fit block allocator.
`default_nettype none

package ffba_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int MAX_GRANTS_DEF = 32;
	localparam int SIZE_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_FREE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE     = 2'd0,
		STAT_NOFIT    = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ASCAN,
		S_FSCAN,
		S_FADD,
		S_EMIT
	} state_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  block_index;
		logic [15:0] block_left;
	} rsp_t;

endpackage

`default_nettype wire

// File: hdl/first_fit_block_allocator_core.sv
// First-fit allocator top level: request channel, sequencer and result register.
// Each request (load a block, allocate, free) gives one result. The block sizes and the
// grant list sit in synchronous memories with one read and one write port, walked one
// entry per cycle. A load writes its block at once; an allocate walks the blocks in
// load order up to the first that fits, and a free walks the whole grant list, which
// also closes the gap left by the removed grant. One request is in work at a time;
// req_stall is high while it is. The result register lets the next request start
// while a result waits.
// Memories need no clearing after reset: only entries below the counts are read.
`default_nettype none

module first_fit_block_allocator_core #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_GRANTS = ffba_pkg::MAX_GRANTS_DEF,
	parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] amount,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [1:0]       status,
	output logic [3:0]       block_index,
	output logic [15:0]      block_left
);

	logic           out_valid_q;
	ffba_pkg::rsp_t out_q;
	ffba_pkg::rsp_t res;
	logic           res_push, res_ready;

	assign res_ready = !out_valid_q || !rsp_stall;

	ffba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_GRANTS (MAX_GRANTS),
		.SIZE_BITS  (SIZE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.amount    (amount),
		.rsp_ready (res_ready),
		.rsp_push  (res_push),
		.rsp       (res)
	);

	// hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			out_q <= res;
	end

	assign rsp_valid   = out_valid_q;
	assign status      = out_q.status;
	assign block_index = out_q.block_index;
	assign block_left  = out_q.block_left;

endmodule

`default_nettype wire

// File: hdl/ffba_ctrl.sv
// Allocator sequencer with the block and grant memories it reads and writes back.
`default_nettype none

module ffba_ctrl #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_GRANTS = ffba_pkg::MAX_GRANTS_DEF,
	parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire logic [1:0]   action,
	input  wire logic [15:0]  amount,
	input  wire logic         rsp_ready,
	output logic              rsp_push,
	output ffba_pkg::rsp_t    rsp
);

	localparam int BI  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int GI  = (MAX_GRANTS > 1) ? $clog2(MAX_GRANTS) : 1;
	localparam int BCW = $clog2(MAX_BLOCKS + 1);
	localparam int GCW = $clog2(MAX_GRANTS + 1);
	localparam int GW  = SIZE_BITS + BI;

	ffba_pkg::state_t state_q, state_d;
	logic [BCW-1:0]       bcnt_q, bcnt_d, bptr_q, bptr_d;
	logic [GCW-1:0]       gcnt_q, gcnt_d, gptr_q, gptr_d;
	logic                 found_q, found_d;
	logic [BI-1:0]        fblk_q, fblk_d;
	logic [SIZE_BITS-1:0] amt_q, amt_d, amt_in;
	ffba_pkg::rsp_t       res_q, res_d;

	// block memory ports
	logic                 bre, bwe;
	logic [BI-1:0]        braddr, bwaddr, baddr_s1;
	logic [SIZE_BITS-1:0] bwdata, brdata_s1;
	logic [SIZE_BITS-1:0] bmem [MAX_BLOCKS];

	// grant memory ports, entry is {size, source block}
	logic                 gre, gwe;
	logic [GI-1:0]        graddr, gwaddr, gaddr_s1;
	logic [GW-1:0]        gwdata, grdata_s1;
	logic [GW-1:0]        gmem [MAX_GRANTS];

	logic                 blk_fit, b_last, g_hit, g_last;
	logic [SIZE_BITS-1:0] blk_left, sat, g_size;
	logic [BI-1:0]        g_blk;
	logic [SIZE_BITS:0]   sum;

	assign amt_in   = SIZE_BITS'(amount);
	assign blk_fit  = brdata_s1 >= amt_q;
	assign blk_left = brdata_s1 - amt_q;
	assign b_last   = (BCW'(baddr_s1) + 1'b1) == bcnt_q;
	assign g_size   = grdata_s1[GW-1:BI];
	assign g_blk    = grdata_s1[BI-1:0];
	assign g_hit    = g_size == amt_q;
	assign g_last   = (GCW'(gaddr_s1) + 1'b1) == gcnt_q;
	assign sum      = {1'b0, brdata_s1} + {1'b0, amt_q};
	assign sat      = sum[SIZE_BITS] ? {SIZE_BITS{1'b1}} : sum[SIZE_BITS-1:0];
	assign rsp      = res_q;

	always_ff @(posedge clk) begin
		if (bwe)
			bmem[bwaddr] <= bwdata;
		if (bre) begin
			brdata_s1 <= bmem[braddr];
			baddr_s1  <= braddr;
		end
	end

	always_ff @(posedge clk) begin
		if (gwe)
			gmem[gwaddr] <= gwdata;
		if (gre) begin
			grdata_s1 <= gmem[graddr];
			gaddr_s1  <= graddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
			bcnt_q  <= '0;
			gcnt_q  <= '0;
			bptr_q  <= '0;
			gptr_q  <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bcnt_q  <= bcnt_d;
			gcnt_q  <= gcnt_d;
			bptr_q  <= bptr_d;
			gptr_q  <= gptr_d;
			found_q <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		amt_q  <= amt_d;
		fblk_q <= fblk_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		bcnt_d    = bcnt_q;
		gcnt_d    = gcnt_q;
		bptr_d    = bptr_q;
		gptr_d    = gptr_q;
		found_d   = found_q;
		fblk_d    = fblk_q;
		amt_d     = amt_q;
		res_d     = res_q;
		bre       = 1'b0;
		braddr    = bptr_q[BI-1:0];
		bwe       = 1'b0;
		bwaddr    = baddr_s1;
		bwdata    = blk_left;
		gre       = 1'b0;
		graddr    = gptr_q[GI-1:0];
		gwe       = 1'b0;
		gwaddr    = gaddr_s1 - 1'b1;
		gwdata    = grdata_s1;
		rsp_push  = 1'b0;
		req_stall = state_q != ffba_pkg::S_IDLE;

		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (req_valid) begin
					amt_d   = amt_in;
					found_d = 1'b0;
					res_d   = '{ffba_pkg::STAT_NOTFOUND, 4'd0, 16'd0};
					state_d = ffba_pkg::S_EMIT;
					case (action)
						ffba_pkg::ACT_LOAD: begin
							if (bcnt_q == BCW'(MAX_BLOCKS)) begin
								res_d.status = ffba_pkg::STAT_FULL;
							end else begin
								bwe    = 1'b1;
								bwaddr = bcnt_q[BI-1:0];
								bwdata = amt_in;
								bcnt_d = bcnt_q + 1'b1;
								res_d  = '{ffba_pkg::STAT_DONE, 4'(bcnt_q[BI-1:0]),
									16'(amt_in)};
							end
						end
						ffba_pkg::ACT_ALLOC: begin
							if (gcnt_q == GCW'(MAX_GRANTS)) begin
								res_d.status = ffba_pkg::STAT_FULL;
							end else if (bcnt_q == '0) begin
								res_d.status = ffba_pkg::STAT_NOFIT;
							end else begin
								bre     = 1'b1;
								braddr  = '0;
								bptr_d  = BCW'(1);
								state_d = ffba_pkg::S_ASCAN;
							end
						end
						ffba_pkg::ACT_FREE: begin
							if (gcnt_q != '0) begin
								gre     = 1'b1;
								graddr  = '0;
								gptr_d  = GCW'(1);
								state_d = ffba_pkg::S_FSCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end

			// one block per cycle in load order; take the first that fits
			ffba_pkg::S_ASCAN: begin
				if (blk_fit) begin
					bwe     = 1'b1;
					gwe     = 1'b1;
					gwaddr  = gcnt_q[GI-1:0];
					gwdata  = {amt_q, baddr_s1};
					gcnt_d  = gcnt_q + 1'b1;
					res_d   = '{ffba_pkg::STAT_DONE, 4'(baddr_s1), 16'(blk_left)};
					state_d = ffba_pkg::S_EMIT;
				end else if (b_last) begin
					res_d   = '{ffba_pkg::STAT_NOFIT, 4'd0, 16'd0};
					state_d = ffba_pkg::S_EMIT;
				end else begin
					bre    = 1'b1;
					bptr_d = bptr_q + 1'b1;
				end
			end

			// find the oldest matching grant and shift the later ones down by one
			ffba_pkg::S_FSCAN: begin
				if (found_q) begin
					gwe = 1'b1;
				end else if (g_hit) begin
					found_d = 1'b1;
					fblk_d  = g_blk;
				end
				if (g_last) begin
					if (found_q || g_hit) begin
						gcnt_d  = gcnt_q - 1'b1;
						bre     = 1'b1;
						braddr  = found_q ? fblk_q : g_blk;
						fblk_d  = braddr;
						state_d = ffba_pkg::S_FADD;
					end else begin
						res_d   = '{ffba_pkg::STAT_NOTFOUND, 4'd0, 16'd0};
						state_d = ffba_pkg::S_EMIT;
					end
				end else begin
					gre    = 1'b1;
					gptr_d = gptr_q + 1'b1;
				end
			end

			// return the freed size to its block, saturating
			ffba_pkg::S_FADD: begin
				bwe     = 1'b1;
				bwaddr  = fblk_q;
				bwdata  = sat;
				res_d   = '{ffba_pkg::STAT_DONE, 4'(fblk_q), 16'(sat)};
				state_d = ffba_pkg::S_EMIT;
			end

			ffba_pkg::S_EMIT: begin
				if (rsp_ready) begin
					rsp_push = 1'b1;
					state_d  = ffba_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = ffba_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
